FILE: design/i2c_eeb_pkg.sv
// ============================================================================
// i2c_eeb_pkg
// Shared types and constants for the I2C EEPROM byte master.
// ============================================================================
package i2c_eeb_pkg;

    // Command codes carried by each tick
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_SELECT = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD   = 2'd1;
    localparam logic [1:0] CFG_WRITE_WAIT    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [6:0]  DEVICE_SELECT_RST = 7'd80;
    localparam logic [7:0]  HALF_PERIOD_RST   = 8'd5;
    localparam logic [15:0] WRITE_WAIT_RST    = 16'd100;

    // Bus sequencer steps
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] ST_START_A   = 4'd1;
    localparam logic [STEP_W-1:0] ST_START_B   = 4'd2;
    localparam logic [STEP_W-1:0] ST_BIT_LOW   = 4'd3;
    localparam logic [STEP_W-1:0] ST_BIT_HIGH  = 4'd4;
    localparam logic [STEP_W-1:0] ST_ACK_LOW   = 4'd5;
    localparam logic [STEP_W-1:0] ST_ACK_HIGH  = 4'd6;
    localparam logic [STEP_W-1:0] ST_STOP_A    = 4'd7;
    localparam logic [STEP_W-1:0] ST_STOP_B    = 4'd8;
    localparam logic [STEP_W-1:0] ST_STOP_C    = 4'd9;
    localparam logic [STEP_W-1:0] ST_RD_LOW    = 4'd10;
    localparam logic [STEP_W-1:0] ST_RD_HIGH   = 4'd11;
    localparam logic [STEP_W-1:0] ST_NACK_LOW  = 4'd12;
    localparam logic [STEP_W-1:0] ST_NACK_HIGH = 4'd13;
    localparam logic [STEP_W-1:0] ST_WAIT      = 4'd14;

    // Byte positions within a transaction
    localparam logic [1:0] BYTE_DEVICE  = 2'd0;
    localparam logic [1:0] BYTE_ADDRESS = 2'd1;
    localparam logic [1:0] BYTE_DATA    = 2'd2;
    localparam logic [1:0] BYTE_READ    = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [6:0]  device_select;
        logic [7:0]  half_period;
        logic [15:0] write_wait;
    } cfg_t;

    // One input tick
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] mem_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // One result
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       rejected;
    } result_t;

endpackage

FILE: design/i2c_eeb_cfg.sv
// ============================================================================
// i2c_eeb_cfg
// Configuration register file: decodes indexed writes into three registers.
// ============================================================================
module i2c_eeb_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output i2c_eeb_pkg::cfg_t  cfg
);
    import i2c_eeb_pkg::*;

    logic [6:0]  device_select_reg;
    logic [7:0]  half_period_reg;
    logic [15:0] write_wait_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_select_reg <= DEVICE_SELECT_RST;
            half_period_reg   <= HALF_PERIOD_RST;
            write_wait_reg    <= WRITE_WAIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEVICE_SELECT: device_select_reg <= cfg_data[6:0];
                CFG_HALF_PERIOD:   half_period_reg   <= cfg_data[7:0];
                CFG_WRITE_WAIT:    write_wait_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.device_select = device_select_reg;
    assign cfg.half_period   = half_period_reg;
    assign cfg.write_wait    = write_wait_reg;

endmodule

FILE: design/i2c_eeb_seq.sv
// ============================================================================
// i2c_eeb_seq
// Bus sequencer: advances the I2C state by one tick per enabled cycle and
// forms the result of that tick.
// ============================================================================
module i2c_eeb_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  i2c_eeb_pkg::item_t    item,
    input  i2c_eeb_pkg::cfg_t     cfg,
    output i2c_eeb_pkg::result_t  res
);
    import i2c_eeb_pkg::*;

    logic [STEP_W-1:0] step_reg,     step_next;
    logic [3:0]        bit_reg,      bit_next;
    logic [1:0]        byte_reg,     byte_next;
    logic [7:0]        shift_reg,    shift_next;
    logic [15:0]       tick_reg,     tick_next;
    logic              is_read_reg,  is_read_next;
    logic [7:0]        addr_reg,     addr_next;
    logic [7:0]        data_reg,     data_next;
    logic              scl_reg,      scl_next;
    logic              sda_reg,      sda_next;
    logic [7:0]        result_reg,   result_next;

    logic              is_cmd;
    logic              entering;
    logic [15:0]       tick_inc;
    logic [15:0]       phase_len;
    logic              phase_done;
    logic [3:0]        bit_inc;
    logic              read_done;

    assign is_cmd   = (item.cmd == CMD_WRITE) || (item.cmd == CMD_READ);
    assign tick_inc = tick_reg + 16'd1;
    assign bit_inc  = bit_reg + 4'd1;

    // Length of the current phase; a zero half period counts as one tick.
    always_comb
    begin
        if (step_reg == ST_WAIT)
            phase_len = cfg.write_wait;
        else if (cfg.half_period == 8'd0)
            phase_len = 16'd1;
        else
            phase_len = {8'd0, cfg.half_period};
    end

    assign phase_done = (tick_inc >= phase_len);

    // Next-state logic for one tick.
    always_comb
    begin
        step_next    = step_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        result_next  = result_reg;
        entering     = 1'b0;
        read_done    = 1'b0;

        if (step_reg == ST_IDLE)
        begin
            if (is_cmd)
            begin
                is_read_next = (item.cmd == CMD_READ);
                addr_next    = item.mem_addr;
                data_next    = item.write_data;
                byte_next    = BYTE_DEVICE;
                bit_next     = 4'd0;
                shift_next   = {cfg.device_select, 1'b0};
                step_next    = ST_START_A;
                entering     = 1'b1;
            end
        end
        else
        begin
            tick_next = tick_inc;
            if (phase_done)
            begin
                entering = 1'b1;
                unique case (step_reg)
                    ST_START_A: step_next = ST_START_B;
                    ST_START_B:
                    begin
                        bit_next  = 4'd0;
                        step_next = ST_BIT_LOW;
                    end
                    ST_BIT_LOW: step_next = ST_BIT_HIGH;
                    ST_BIT_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_inc;
                        step_next  = (bit_inc >= BITS_PER_BYTE) ? ST_ACK_LOW : ST_BIT_LOW;
                    end
                    ST_ACK_LOW: step_next = ST_ACK_HIGH;
                    ST_ACK_HIGH:
                    begin
                        if (byte_reg == BYTE_DEVICE)
                        begin
                            byte_next  = BYTE_ADDRESS;
                            shift_next = addr_reg;
                            bit_next   = 4'd0;
                            step_next  = ST_BIT_LOW;
                        end
                        else if (byte_reg == BYTE_ADDRESS)
                        begin
                            if (is_read_reg)
                                step_next = ST_STOP_A;
                            else
                            begin
                                byte_next  = BYTE_DATA;
                                shift_next = data_reg;
                                bit_next   = 4'd0;
                                step_next  = ST_BIT_LOW;
                            end
                        end
                        else if (byte_reg == BYTE_DATA && is_read_reg)
                        begin
                            byte_next  = BYTE_READ;
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            step_next  = ST_RD_LOW;
                        end
                        else
                            step_next = ST_STOP_A;
                    end
                    ST_RD_LOW: step_next = ST_RD_HIGH;
                    ST_RD_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], item.sda_in};
                        bit_next   = bit_inc;
                        step_next  = (bit_inc >= BITS_PER_BYTE) ? ST_NACK_LOW : ST_RD_LOW;
                    end
                    ST_NACK_LOW:  step_next = ST_NACK_HIGH;
                    ST_NACK_HIGH: step_next = ST_STOP_A;
                    ST_STOP_A:    step_next = ST_STOP_B;
                    ST_STOP_B:    step_next = ST_STOP_C;
                    ST_STOP_C:
                    begin
                        if (!is_read_reg)
                            step_next = (cfg.write_wait != 16'd0) ? ST_WAIT : ST_IDLE;
                        else if (byte_reg == BYTE_ADDRESS)
                        begin
                            // Repeated transaction for the read phase
                            byte_next  = BYTE_DATA;
                            shift_next = {cfg.device_select, 1'b1};
                            step_next  = ST_START_A;
                        end
                        else
                        begin
                            result_next = shift_reg;
                            read_done   = 1'b1;
                            step_next   = ST_IDLE;
                        end
                    end
                    default: step_next = ST_IDLE;
                endcase
            end
        end

        // Line levels set on entry to a step
        scl_next = scl_reg;
        sda_next = sda_reg;
        if (entering)
        begin
            tick_next = 16'd0;
            unique case (step_next) inside
                ST_START_A:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                ST_START_B, ST_STOP_B:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                ST_BIT_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                end
                ST_BIT_HIGH: scl_next = 1'b1;
                ST_ACK_LOW, ST_RD_LOW, ST_NACK_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                ST_STOP_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                default:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            bit_reg     <= 4'd0;
            byte_reg    <= BYTE_DEVICE;
            shift_reg   <= 8'd0;
            tick_reg    <= 16'd0;
            is_read_reg <= 1'b0;
            addr_reg    <= 8'd0;
            data_reg    <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            result_reg  <= 8'd0;
        end
        else if (step_en)
        begin
            step_reg    <= step_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            tick_reg    <= tick_next;
            is_read_reg <= is_read_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            result_reg  <= result_next;
        end
    end

    // Result of this tick
    assign res.scl        = scl_next;
    assign res.sda_out    = sda_next;
    assign res.busy_res   = (step_next != ST_IDLE);
    assign res.read_data  = result_next;
    assign res.read_valid = read_done;
    assign res.rejected   = is_cmd && (step_reg != ST_IDLE);

    // A completed read always returns the sequencer to idle.
    a_read_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && read_done |=> step_reg == ST_IDLE)
        else $error("read completion did not return to idle");

    // The bit counter never passes one byte.
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BITS_PER_BYTE)
        else $error("bit index out of range");

    // Without a tick the sequencer state holds.
    a_hold_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(step_reg) && $stable(tick_reg))
        else $error("sequencer moved without a tick");

    // A read result is only signalled while leaving the final stop.
    a_read_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
        read_done |-> step_reg == ST_STOP_C && is_read_reg)
        else $error("read result outside the final stop");

endmodule

FILE: design/i2c_eeprom_byte_master_core.sv
// ============================================================================
// i2c_eeprom_byte_master_core
// I2C master for a serial EEPROM: single-byte write and random read.
// ============================================================================
// Usage
//   The input channel (in_valid/in_stall) carries one timing tick per
//   transaction with cmd, mem_addr, write_data and the sampled sda_in. Every
//   accepted tick produces exactly one result transaction on the output
//   channel (out_valid/out_stall) with the SCL and SDA drive levels, the busy
//   flag, the last read byte, a read-complete strobe and a rejection flag.
//   A tick passes through the input register and then the result register,
//   with the sequencer update between the two registers; throughput is one
//   tick per cycle while out_stall does not hold the result register.
//   When out_stall is high the result register holds; the input register
//   keeps one more tick and in_stall rises only once both are full.
//   Configuration (device_select, half_period, write_wait) is written through
//   cfg_write/cfg_index/cfg_data while no tick is held in either register.
//   Reset returns the sequencer to idle with both lines released, clears the
//   read byte and loads the default configuration.
// ============================================================================
module i2c_eeprom_byte_master_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  mem_addr,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl,
    output logic        sda_out,
    output logic        busy_res,
    output logic [7:0]  read_data,
    output logic        read_valid,
    output logic        rejected
);
    import i2c_eeb_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    step_en;
    logic    in_take;

    // Configuration registers
    i2c_eeb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: a held tick advances whenever the result register is free.
    assign step_en         = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall        = item_valid_reg && !step_en;
    assign in_take         = in_valid && !in_stall;
    assign item_valid_next = in_take || (item_valid_reg && !step_en);
    assign out_valid_next  = step_en || (out_valid_reg && out_stall);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd        <= cmd;
            item_reg.mem_addr   <= mem_addr;
            item_reg.write_data <= write_data;
            item_reg.sda_in     <= sda_in;
        end
    end

    // Bus sequencer
    i2c_eeb_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign scl        = res_reg.scl;
    assign sda_out    = res_reg.sda_out;
    assign busy_res   = res_reg.busy_res;
    assign read_data  = res_reg.read_data;
    assign read_valid = res_reg.read_valid;
    assign rejected   = res_reg.rejected;

endmodule
